// File: design/lbf_pkg.sv
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types, constants and helpers of the learning bridge forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package lbf_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PORTS_DEF         = 8;

  localparam int MAC_W   = 48;
  localparam int TICK_W  = 32;
  localparam int PORT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int NPORT_W = 4;
  localparam int PTYPE_W = 2;

  localparam int GROUP_BIT = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PORTS = 2'd3;

  localparam logic [TICK_W-1:0]  EXPIRY_RESET    = 32'd300;
  localparam logic [NPORT_W-1:0] NUM_PORTS_RESET = 4'd8;

  // packet type codes
  localparam logic [PTYPE_W-1:0] PT_HOST  = 2'd0;
  localparam logic [PTYPE_W-1:0] PT_BCAST = 2'd1;
  localparam logic [PTYPE_W-1:0] PT_MCAST = 2'd2;
  localparam logic [PTYPE_W-1:0] PT_OTHER = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TICK_W-1:0] expiry;
  } lbf_entry_t;

  // item context handed to the result logic
  typedef struct packed {
    logic               mode;
    logic [PORT_W-1:0]  in_port;
    logic [PTYPE_W-1:0] ptype;
    logic               to_bridge;
  } lbf_ctl_t;

  // outcome of the table passes
  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic              dropped;
  } lbf_look_t;

  typedef struct packed {
    logic              deliver_local;
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              learn_dropped;
  } lbf_res_t;

  // active port count: num_ports clamped to the port count of the build
  function automatic logic [NPORT_W-1:0] act_ports(input logic [NPORT_W-1:0] n,
                                                   input int unsigned ports);
    if (32'(n) > ports) return NPORT_W'(ports);
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/lbf_if.sv
// ----------------------------------------------------------------------------
// lbf_if
// Valid/ready channels of the learning bridge forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbf_item_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lbf_pkg::PORT_W-1:0]  in_port;
  logic [lbf_pkg::MAC_W-1:0]   src_mac;
  logic [lbf_pkg::MAC_W-1:0]   dst_mac;
  logic [lbf_pkg::PTYPE_W-1:0] packet_type;
  logic [lbf_pkg::TICK_W-1:0]  now_ticks;

  modport source (output valid, mode, in_port, src_mac, dst_mac, packet_type, now_ticks,
                  input ready);
  modport sink   (input valid, mode, in_port, src_mac, dst_mac, packet_type, now_ticks,
                  output ready);
endinterface

interface lbf_result_if;
  logic                       valid;
  logic                       ready;
  logic                       deliver_local;
  logic [lbf_pkg::MASK_W-1:0] egress_mask;
  logic                       flooded;
  logic                       learn_dropped;

  modport source (output valid, deliver_local, egress_mask, flooded, learn_dropped,
                  input ready);
  modport sink   (input valid, deliver_local, egress_mask, flooded, learn_dropped,
                  output ready);
endinterface

`default_nettype wire

// File: design/learning_bridge_forwarder.sv
// ----------------------------------------------------------------------------
// learning_bridge_forwarder
// Learning Ethernet bridge with aged entries: learns source MACs, looks up
// destinations in a table with one write and one read port and returns the decision.
// ----------------------------------------------------------------------------
// Sequence: accept, learn scan of the table, write of the learned entry, lookup
//   scan, invalidate of an expired entry, finish; an item that needs no table
//   work goes straight from accept to finish.
// Flow: no new item is taken until the last one has passed finish, which a
//   result stall can hold; the table port reads one entry a cycle.
// Reset: synchronous, active low; a clearing pass over every entry follows,
//   with in_item.ready low. Configuration writes are taken in every state out of reset.
`default_nettype none

module learning_bridge_forwarder #(
  parameter int TABLE_ENTRIES = lbf_pkg::TABLE_ENTRIES_DEF,
  parameter int PORTS         = lbf_pkg::PORTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lbf_item_if.sink                        in_item,
  lbf_result_if.source                    out_res,
  input  logic                            cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEARN_SCAN,
    S_LEARN_WR,
    S_LOOK_SCAN,
    S_LOOK_WR,
    S_FINISH
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                        learn_en_r;
  logic [lbf_pkg::TICK_W-1:0]  expiry_r;
  logic [lbf_pkg::MAC_W-1:0]   bridge_mac_r;
  logic [lbf_pkg::NPORT_W-1:0] num_ports_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_en_r   <= 1'b1;
      expiry_r     <= lbf_pkg::EXPIRY_RESET;
      bridge_mac_r <= '0;
      num_ports_r  <= lbf_pkg::NUM_PORTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbf_pkg::CFG_LEARN_EN:  learn_en_r   <= cfg_wdata[0];
        lbf_pkg::CFG_EXPIRY:    expiry_r     <= cfg_wdata[lbf_pkg::TICK_W-1:0];
        lbf_pkg::CFG_BRIDGE:    bridge_mac_r <= cfg_wdata[lbf_pkg::MAC_W-1:0];
        lbf_pkg::CFG_NUM_PORTS: num_ports_r  <= cfg_wdata[lbf_pkg::NPORT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and item registers
  // --------------------------------------------------------------------------
  state_t                      state_r;
  logic [CNTW-1:0]             iss_r;       // next table address to read / clear
  logic                        rd_vld_r;    // rd_q_r holds entry rd_idx_r
  logic [IDXW-1:0]             rd_idx_r;
  lbf_pkg::lbf_entry_t         rd_q_r;
  logic [lbf_pkg::MAC_W-1:0]   key_r;       // MAC searched by the running scan
  logic                        mode_r;
  logic [lbf_pkg::PORT_W-1:0]  port_r;
  logic [lbf_pkg::PTYPE_W-1:0] ptype_r;
  logic                        tobr_r;
  logic [lbf_pkg::MAC_W-1:0]   src_r;
  logic [lbf_pkg::MAC_W-1:0]   dst_r;
  logic [lbf_pkg::TICK_W-1:0]  now_r;
  logic                        need_look_r;
  logic                        free_found_r;
  logic [IDXW-1:0]             free_idx_r;
  logic [IDXW-1:0]             wr_idx_r;
  lbf_pkg::lbf_look_t          look_r;
  logic                        out_valid_r;
  lbf_pkg::lbf_res_t           res_r;

  // table: one write and one registered read a cycle
  lbf_pkg::lbf_entry_t table_mem [TABLE_ENTRIES];

  // --------------------------------------------------------------------------
  // Accept-time decode
  // --------------------------------------------------------------------------
  logic [lbf_pkg::NPORT_W-1:0] act;
  logic                        in_act;
  logic                        tobr_in;
  logic                        bcast_in;
  logic                        need_learn_in;
  logic                        need_look_in;

  always_comb begin
    act      = lbf_pkg::act_ports(num_ports_r, PORTS);
    in_act   = {1'b0, in_item.in_port} < act;
    tobr_in  = in_item.dst_mac == bridge_mac_r;
    bcast_in = in_item.packet_type == lbf_pkg::PT_BCAST ||
               in_item.packet_type == lbf_pkg::PT_MCAST;
    // frames from an inactive port or local sends learn nothing
    need_learn_in = learn_en_r && !in_item.mode && in_act &&
                    (bcast_in || tobr_in || in_item.packet_type == lbf_pkg::PT_OTHER);
    // local unicast sends and received frames for another host get a lookup
    need_look_in  = learn_en_r &&
                    (in_item.mode ? !in_item.dst_mac[lbf_pkg::GROUP_BIT]
                                  : (in_act && !tobr_in &&
                                     in_item.packet_type == lbf_pkg::PT_OTHER));
  end

  assign in_item.ready = (state_r == S_IDLE);

  // --------------------------------------------------------------------------
  // Scan datapath: one entry compared per cycle
  // --------------------------------------------------------------------------
  logic                        rd_en;
  logic [IDXW-1:0]             rd_addr;
  logic                        key_hit;
  logic                        slot_free;
  logic                        last;
  logic                        scan_end;
  logic [lbf_pkg::TICK_W-1:0]  diff;
  logic                        expired;
  logic                        out_free;

  always_comb begin
    rd_en     = (state_r == S_LEARN_SCAN || state_r == S_LOOK_SCAN) &&
                (iss_r < CNTW'(TABLE_ENTRIES));
    rd_addr   = iss_r[IDXW-1:0];
    key_hit   = rd_vld_r && rd_q_r.valid && (rd_q_r.mac == key_r);
    slot_free = rd_vld_r && !rd_q_r.valid;
    last      = rd_idx_r == IDXW'(TABLE_ENTRIES - 1);
    scan_end  = rd_vld_r && (key_hit || last);
    // wrapping clock: live while expiry - now is positive as a signed value
    diff      = rd_q_r.expiry - now_r;
    expired   = (diff == '0) || diff[lbf_pkg::TICK_W-1];
    out_free  = !out_valid_r || out_res.ready;
  end

  // table write port
  logic                        mem_we;
  logic [IDXW-1:0]             mem_wa;
  lbf_pkg::lbf_entry_t         mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_idx_r;
    mem_wd = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = iss_r[IDXW-1:0];
      end
      S_LEARN_WR: begin
        // refresh and insert write the same entry
        mem_we        = 1'b1;
        mem_wd.valid  = 1'b1;
        mem_wd.mac    = src_r;
        mem_wd.port   = port_r;
        mem_wd.expiry = now_r + expiry_r;
      end
      S_LOOK_WR: begin
        mem_we = 1'b1;    // expired entry dropped
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= table_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result logic
  // --------------------------------------------------------------------------
  lbf_pkg::lbf_ctl_t ctl;
  lbf_pkg::lbf_res_t res_calc;

  assign ctl = '{mode: mode_r, in_port: port_r, ptype: ptype_r, to_bridge: tobr_r};

  lbf_fwd_calc #(
    .PORTS (PORTS)
  ) u_lbf_fwd_calc (
    .ctl       (ctl),
    .look      (look_r),
    .num_ports (num_ports_r),
    .res       (res_calc)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FINISH the result register is handled below
      if (out_res.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= rd_en && !scan_end;
      rd_idx_r <= rd_addr;
      if (rd_en) begin
        iss_r <= iss_r + CNTW'(1);
      end

      unique case (state_r)
        S_CLEAR: begin
          iss_r <= iss_r + CNTW'(1);
          if (iss_r == CNTW'(TABLE_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_item.valid) begin
            mode_r       <= in_item.mode;
            port_r       <= in_item.in_port;
            ptype_r      <= in_item.packet_type;
            tobr_r       <= tobr_in;
            src_r        <= in_item.src_mac;
            dst_r        <= in_item.dst_mac;
            now_r        <= in_item.now_ticks;
            need_look_r  <= need_look_in;
            free_found_r <= 1'b0;
            look_r       <= '0;
            iss_r        <= '0;
            key_r        <= need_learn_in ? in_item.src_mac : in_item.dst_mac;
            priority if (need_learn_in) begin
              state_r <= S_LEARN_SCAN;
            end else if (need_look_in) begin
              state_r <= S_LOOK_SCAN;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end

        S_LEARN_SCAN: begin
          if (slot_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= rd_idx_r;
          end
          if (key_hit) begin
            wr_idx_r <= rd_idx_r;
            state_r  <= S_LEARN_WR;
          end else if (rd_vld_r && last) begin
            if (free_found_r || slot_free) begin
              wr_idx_r <= free_found_r ? free_idx_r : rd_idx_r;
              state_r  <= S_LEARN_WR;
            end else begin
              // table full: source not stored
              look_r.dropped <= 1'b1;
              iss_r          <= '0;
              key_r          <= dst_r;
              state_r        <= need_look_r ? S_LOOK_SCAN : S_FINISH;
            end
          end
        end

        S_LEARN_WR: begin
          iss_r   <= '0;
          key_r   <= dst_r;
          state_r <= need_look_r ? S_LOOK_SCAN : S_FINISH;
        end

        S_LOOK_SCAN: begin
          if (key_hit) begin
            if (expired) begin
              wr_idx_r <= rd_idx_r;
              state_r  <= S_LOOK_WR;
            end else begin
              look_r.hit  <= 1'b1;
              look_r.port <= rd_q_r.port;
              state_r     <= S_FINISH;
            end
          end else if (rd_vld_r && last) begin
            state_r <= S_FINISH;
          end
        end

        S_LOOK_WR: begin
          state_r <= S_FINISH;
        end

        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            res_r       <= res_calc;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_CLEAR;
          iss_r   <= '0;
        end
      endcase
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.deliver_local = res_r.deliver_local;
  assign out_res.egress_mask   = res_r.egress_mask;
  assign out_res.flooded       = res_r.flooded;
  assign out_res.learn_dropped = res_r.learn_dropped;

endmodule

`default_nettype wire

// File: design/lbf_fwd_calc.sv
// ----------------------------------------------------------------------------
// lbf_fwd_calc
// Forwarding decision: local delivery, egress mask and flags of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_fwd_calc #(
  parameter int PORTS = lbf_pkg::PORTS_DEF
) (
  input  lbf_pkg::lbf_ctl_t             ctl,
  input  lbf_pkg::lbf_look_t            look,
  input  logic [lbf_pkg::NPORT_W-1:0]   num_ports,
  output lbf_pkg::lbf_res_t             res
);

  logic [lbf_pkg::NPORT_W-1:0] act;
  logic [lbf_pkg::MASK_W-1:0]  all_m;
  logic [lbf_pkg::MASK_W-1:0]  others;
  logic [lbf_pkg::MASK_W-1:0]  single;
  logic                        look_ok;
  logic                        in_act;

  always_comb begin
    act = lbf_pkg::act_ports(num_ports, PORTS);
    for (int j = 0; j < lbf_pkg::MASK_W; j++) begin
      all_m[j] = (lbf_pkg::NPORT_W'(j) < act);
    end
    others  = all_m & ~(lbf_pkg::MASK_W'(1) << ctl.in_port);
    single  = lbf_pkg::MASK_W'(1) << look.port;
    // learned port must still be active
    look_ok = look.hit && ({1'b0, look.port} < act);
    in_act  = {1'b0, ctl.in_port} < act;

    res = '0;
    if (ctl.mode) begin
      if (look_ok) begin
        res.egress_mask = single;
      end else begin
        res.egress_mask = all_m;
        res.flooded     = 1'b1;
      end
    end else if (in_act) begin
      priority if (ctl.ptype == lbf_pkg::PT_BCAST || ctl.ptype == lbf_pkg::PT_MCAST) begin
        res.deliver_local = 1'b1;
        res.egress_mask   = others;
        res.flooded       = 1'b1;
        res.learn_dropped = look.dropped;
      end else if (ctl.to_bridge) begin
        res.deliver_local = 1'b1;
        res.learn_dropped = look.dropped;
      end else if (ctl.ptype == lbf_pkg::PT_OTHER) begin
        res.learn_dropped = look.dropped;
        if (look_ok && look.port != ctl.in_port) begin
          res.egress_mask = single;
        end else begin
          res.egress_mask = others;
          res.flooded     = 1'b1;
        end
      end else begin
        res = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lbf_checker.sv
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level assertions of the learning bridge forwarder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       deliver_local,
  input logic [lbf_pkg::MASK_W-1:0] egress_mask,
  input logic                       flooded,
  input logic                       learn_dropped
);

  logic [1:0] pend_r;   // items accepted and not yet delivered
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({deliver_local, egress_mask, flooded, learn_dropped}))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after an accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending item");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !flooded && egress_mask != '0 |-> $onehot(egress_mask) && !deliver_local)
    else $error("learned forward not on a single port");

endmodule

bind learning_bridge_forwarder lbf_checker u_lbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .deliver_local (out_res.deliver_local),
  .egress_mask   (out_res.egress_mask),
  .flooded       (out_res.flooded),
  .learn_dropped (out_res.learn_dropped)
);

`default_nettype wire
